@@ hw/rtl/hmbq_pkg.sv @@
package hmbq_pkg;

  localparam int DEF_MAP_ENTRIES = 65536;
  localparam int DEF_SAMPLE_BITS = 16;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int DIM_W      = 9;
  localparam int RECIP_W    = 32;
  localparam int SCALE_W    = 16;
  localparam int COORD_W    = 24;
  localparam int LOAD_IDX_W = 16;
  localparam int LOAD_DAT_W = 16;
  localparam int FRAC_W     = 16;
  localparam int UNIT_W     = 25;
  localparam int ROW_IDX_W  = 2 * DIM_W;
  localparam int RESULT_W   = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MAP_WIDTH       = 3'd0,
    REG_MAP_HEIGHT      = 3'd1,
    REG_INV_WORLD_WIDTH = 3'd2,
    REG_INV_WORLD_DEPTH = 3'd3,
    REG_HEIGHT_SCALE    = 3'd4
  } cfg_reg_t;

  localparam logic [DIM_W-1:0]          RST_MAP_WIDTH    = 9'd256;
  localparam logic [DIM_W-1:0]          RST_MAP_HEIGHT   = 9'd256;
  localparam logic [RECIP_W-1:0]        RST_INV_WORLD    = 32'h0100_0000;
  localparam logic signed [SCALE_W-1:0] RST_HEIGHT_SCALE = 16'sh0100;

endpackage

@@ hw/rtl/hmbq_ram.sv @@
module hmbq_ram #(
  parameter int WIDTH = hmbq_pkg::DEF_SAMPLE_BITS,
  parameter int DEPTH = hmbq_pkg::DEF_MAP_ENTRIES
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hw/rtl/heightmap_bilinear_query.sv @@
// Heightmap height query with bilinear interpolation.
// Command channel: a transaction is taken at a rising edge with start high and
// busy low. busy is always low, so one command may be taken every cycle.
// op low loads one sample (load_index, load_height) and gives no result; op
// high queries world position (query_x, query_z) in Q15.8.
// Result: done is high for exactly one cycle with height_out and in_bounds.
// Sustained rate is one command per cycle; the query path has thirteen register
// stages, with the sample memory read in the sixth. Four copies of the sample
// memory are each written by every load and read at one of the four neighbours
// of a query.
// Configuration: cfg_valid/cfg_ready write channel, cfg_ready always high;
// cfg_index picks the register, cfg_data carries the value. Write only while
// no command is in flight.
// Reset clears the pipeline and restores register defaults; the sample memory
// is not cleared and must be loaded before it is queried. The receiver cannot
// stall: results leave on the cycle they are shown.
module heightmap_bilinear_query #(
  parameter int MAP_ENTRIES = hmbq_pkg::DEF_MAP_ENTRIES,
  parameter int SAMPLE_BITS = hmbq_pkg::DEF_SAMPLE_BITS
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   start,
  output logic                                   busy,
  input  logic                                   op,
  input  logic [hmbq_pkg::LOAD_IDX_W-1:0]        load_index,
  input  logic signed [hmbq_pkg::LOAD_DAT_W-1:0] load_height,
  input  logic signed [hmbq_pkg::COORD_W-1:0]    query_x,
  input  logic signed [hmbq_pkg::COORD_W-1:0]    query_z,
  output logic                                   done,
  output logic signed [hmbq_pkg::RESULT_W-1:0]   height_out,
  output logic                                   in_bounds,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [hmbq_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [hmbq_pkg::CFG_DATA_W-1:0]        cfg_data
);
  import hmbq_pkg::*;

  localparam int ADDR_W = $clog2(MAP_ENTRIES);
  localparam int IW     = (ADDR_W > ROW_IDX_W) ? ADDR_W : ROW_IDX_W;
  localparam int PX_W   = COORD_W + RECIP_W + 1;
  localparam int SX_W   = PX_W + 1;
  localparam int FX_W   = UNIT_W + DIM_W;
  localparam int LW     = SAMPLE_BITS + FRAC_W + 1;
  localparam int MW     = LW + 1;
  localparam int DW     = LW + 1;
  localparam int YW     = DW + FRAC_W + 1;
  localparam int PW     = LW + SCALE_W;
  localparam int QSTG   = 13;
  localparam int LSTG   = 5;

  localparam logic [SX_W-10:0]      UNIT_ONE = (SX_W-9)'(1) << 24;
  localparam logic signed [PW-1:0]  RES_MAX  = PW'(64'sh7FFF_FFFF);
  localparam logic signed [PW-1:0]  RES_MIN  = PW'(-64'sh8000_0000);

  // configuration registers
  logic [DIM_W-1:0]          map_width;
  logic [DIM_W-1:0]          map_height;
  logic [RECIP_W-1:0]        inv_world_width;
  logic [RECIP_W-1:0]        inv_world_depth;
  logic signed [SCALE_W-1:0] height_scale;

  logic [DIM_W-1:0] w_eff, h_eff, wm1, hm1;

  // pipeline control
  logic [QSTG-1:0] qv;
  logic [LSTG-1:0] lv;
  logic [QSTG-2:1] ib;

  // load payload
  logic [LOAD_IDX_W-1:0]  ld_idx [LSTG];
  logic [SAMPLE_BITS-1:0] ld_dat [LSTG];
  logic [IW-1:0]          ld_ext;

  // query datapath
  logic signed [PX_W-1:0] px1, pz1;
  logic signed [SX_W-1:0] sx, sz;
  logic                   okx, oky;
  logic [UNIT_W-1:0]      ux2, uz2;
  logic [FX_W-1:0]        fx3, fy3;
  logic [DIM_W-1:0]       x0n, y0n, x1n, y1n;
  logic [DIM_W-1:0]       x0_4, x1_4, y0_4, y1_4;
  logic [FRAC_W-1:0]      ax4, ay4, ax5, ay5, ax6, ay6, ay7, ay8, ay9;
  logic [ROW_IDX_W-1:0]   row0_5, row1_5;
  logic [DIM_W-1:0]       x0_5, x1_5;
  logic [IW-1:0]          idx [4];
  logic [ADDR_W-1:0]      raddr [4];
  logic [SAMPLE_BITS-1:0] rdata [4];
  logic signed [SAMPLE_BITS:0] dtop, dbot;
  logic signed [MW-1:0]   mt7, mb7;
  logic signed [SAMPLE_BITS-1:0] a7, c7;
  logic signed [LW-1:0]   top8, bot8, top9, top10, h11;
  logic signed [DW-1:0]   dv9;
  logic signed [YW-1:0]   my10;
  logic signed [PW-1:0]   p12, res;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign done      = qv[QSTG-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      map_width       <= RST_MAP_WIDTH;
      map_height      <= RST_MAP_HEIGHT;
      inv_world_width <= RST_INV_WORLD;
      inv_world_depth <= RST_INV_WORLD;
      height_scale    <= RST_HEIGHT_SCALE;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_MAP_WIDTH:       map_width       <= cfg_data[DIM_W-1:0];
        REG_MAP_HEIGHT:      map_height      <= cfg_data[DIM_W-1:0];
        REG_INV_WORLD_WIDTH: inv_world_width <= cfg_data[RECIP_W-1:0];
        REG_INV_WORLD_DEPTH: inv_world_depth <= cfg_data[RECIP_W-1:0];
        REG_HEIGHT_SCALE:    height_scale    <= cfg_data[SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  // a zero dimension behaves as one
  assign w_eff = (map_width == '0) ? DIM_W'(1) : map_width;
  assign h_eff = (map_height == '0) ? DIM_W'(1) : map_height;
  assign wm1   = w_eff - DIM_W'(1);
  assign hm1   = h_eff - DIM_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      qv <= '0;
      lv <= '0;
    end else begin
      qv <= {qv[QSTG-2:0], start & ~busy & op};
      lv <= {lv[LSTG-2:0], start & ~busy & ~op};
    end
  end

  // stage 1: coordinate times reciprocal, load capture
  always_ff @(posedge clk) begin
    px1       <= query_x * $signed({1'b0, inv_world_width});
    pz1       <= query_z * $signed({1'b0, inv_world_depth});
    ld_idx[0] <= load_index;
    ld_dat[0] <= SAMPLE_BITS'(load_height);
    for (int i = 1; i < LSTG; i++) begin
      ld_idx[i] <= ld_idx[i-1];
      ld_dat[i] <= ld_dat[i-1];
    end
  end

  // stage 2: add one half, bounds check
  assign sx  = SX_W'(px1) + (SX_W'(1) <<< 31);
  assign sz  = SX_W'(pz1) + (SX_W'(1) <<< 31);
  assign okx = !sx[SX_W-1] && (sx[SX_W-2:8] <= UNIT_ONE);
  assign oky = !sz[SX_W-1] && (sz[SX_W-2:8] <= UNIT_ONE);

  always_ff @(posedge clk) begin
    ux2 <= sx[UNIT_W+7:8];
    uz2 <= sz[UNIT_W+7:8];
    ib  <= {ib[QSTG-3:1], okx & oky};
  end

  // stage 3: scale to grid
  always_ff @(posedge clk) begin
    fx3 <= ux2 * wm1;
    fy3 <= uz2 * hm1;
  end

  // stage 4: cell corners and fractions, clamp the far index at the edge
  assign x0n = fx3[DIM_W+23:24];
  assign y0n = fy3[DIM_W+23:24];
  assign x1n = (({1'b0, x0n} + (DIM_W+1)'(1)) < {1'b0, w_eff}) ? x0n + DIM_W'(1) : x0n;
  assign y1n = (({1'b0, y0n} + (DIM_W+1)'(1)) < {1'b0, h_eff}) ? y0n + DIM_W'(1) : y0n;

  always_ff @(posedge clk) begin
    x0_4 <= x0n;
    x1_4 <= x1n;
    y0_4 <= y0n;
    y1_4 <= y1n;
    ax4  <= fx3[23:8];
    ay4  <= fy3[23:8];
  end

  // stage 5: row offsets
  always_ff @(posedge clk) begin
    row0_5 <= y0_4 * w_eff;
    row1_5 <= y1_4 * w_eff;
    x0_5   <= x0_4;
    x1_5   <= x1_4;
    ax5    <= ax4;
    ay5    <= ay4;
  end

  // stage 6: memory read, loads write in the same stage to keep order
  assign idx[0] = IW'(row0_5) + IW'(x0_5);
  assign idx[1] = IW'(row0_5) + IW'(x1_5);
  assign idx[2] = IW'(row1_5) + IW'(x0_5);
  assign idx[3] = IW'(row1_5) + IW'(x1_5);
  assign ld_ext = IW'(ld_idx[LSTG-1]);

  for (genvar g = 0; g < 4; g++) begin : g_bank
    assign raddr[g] = idx[g][ADDR_W-1:0];

    hmbq_ram #(
      .WIDTH (SAMPLE_BITS),
      .DEPTH (MAP_ENTRIES)
    ) u_ram (
      .clk   (clk),
      .we    (lv[LSTG-1]),
      .waddr (ld_ext[ADDR_W-1:0]),
      .wdata (ld_dat[LSTG-1]),
      .raddr (raddr[g]),
      .rdata (rdata[g])
    );
  end

  always_ff @(posedge clk) begin
    ax6 <= ax5;
    ay6 <= ay5;
  end

  // stage 7: horizontal slope times fraction
  assign dtop = $signed({rdata[1][SAMPLE_BITS-1], rdata[1]})
              - $signed({rdata[0][SAMPLE_BITS-1], rdata[0]});
  assign dbot = $signed({rdata[3][SAMPLE_BITS-1], rdata[3]})
              - $signed({rdata[2][SAMPLE_BITS-1], rdata[2]});

  always_ff @(posedge clk) begin
    mt7 <= dtop * $signed({1'b0, ax6});
    mb7 <= dbot * $signed({1'b0, ax6});
    a7  <= $signed(rdata[0]);
    c7  <= $signed(rdata[2]);
    ay7 <= ay6;
  end

  // stage 8: horizontal lerps
  always_ff @(posedge clk) begin
    top8 <= (LW'(a7) <<< FRAC_W) + LW'(mt7);
    bot8 <= (LW'(c7) <<< FRAC_W) + LW'(mb7);
    ay8  <= ay7;
  end

  // stage 9: vertical slope
  always_ff @(posedge clk) begin
    dv9  <= DW'(bot8) - DW'(top8);
    top9 <= top8;
    ay9  <= ay8;
  end

  // stage 10: vertical slope times fraction
  always_ff @(posedge clk) begin
    my10  <= dv9 * $signed({1'b0, ay9});
    top10 <= top9;
  end

  // stage 11: vertical lerp, floor to Q.16
  always_ff @(posedge clk) begin
    h11 <= top10 + LW'(my10 >>> FRAC_W);
  end

  // stage 12: apply height scale
  always_ff @(posedge clk) begin
    p12 <= h11 * height_scale;
  end

  // stage 13: floor to integer, saturate, drop the value when out of bounds
  assign res = p12 >>> 24;

  always_ff @(posedge clk) begin
    in_bounds <= ib[QSTG-2];
    if (!ib[QSTG-2]) begin
      height_out <= '0;
    end else if (res > RES_MAX) begin
      height_out <= RES_MAX[RESULT_W-1:0];
    end else if (res < RES_MIN) begin
      height_out <= RES_MIN[RESULT_W-1:0];
    end else begin
      height_out <= res[RESULT_W-1:0];
    end
  end

`ifndef SYNTHESIS
  a_query_result : assert property (@(posedge clk) disable iff (rst)
    (start && !busy && op) |-> ##13 done)
    else $error("query transaction did not produce a result");

  a_load_silent : assert property (@(posedge clk) disable iff (rst)
    (start && !busy && !op) |-> ##13 !done)
    else $error("load transaction produced a result");

  a_out_of_bounds_zero : assert property (@(posedge clk) disable iff (rst)
    (done && !in_bounds) |-> (height_out == '0))
    else $error("out-of-bounds result carries a height");

  a_corner_in_map : assert property (@(posedge clk) disable iff (rst)
    (qv[3] && ib[3]) |-> ((x1_4 < w_eff) && (y1_4 < h_eff) &&
                          (x1_4 - x0_4 <= DIM_W'(1)) && (y1_4 - y0_4 <= DIM_W'(1))))
    else $error("neighbour index outside the map");
`endif

endmodule

@@ tb/sv/heightmap_bilinear_query_tb.sv @@
module heightmap_bilinear_query_tb;
  import hmbq_pkg::*;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;
  localparam longint COORD_LIM   = 64'sd8388608;
  localparam int     SETTLE      = 20;
  localparam int     CYCLE_LIMIT = 150000;
  localparam int     PRINT_CAP   = 100;

  typedef struct packed {
    logic                           op;
    logic [LOAD_IDX_W-1:0]          load_index;
    logic signed [LOAD_DAT_W-1:0]   load_height;
    logic signed [COORD_W-1:0]      query_x;
    logic signed [COORD_W-1:0]      query_z;
  } terrain_cmd_t;

  typedef struct packed {
    logic signed [RESULT_W-1:0] height;
    logic                       in_bounds;
  } height_result_t;

  // Four neighbour addresses, order (z0,x0) (z0,x1) (z1,x0) (z1,x1), plus fractions.
  typedef struct packed {
    logic                             inb;
    logic [3:0][LOAD_IDX_W-1:0]       idx;
    logic [FRAC_W-1:0]                ax;
    logic [FRAC_W-1:0]                az;
  } taps_t;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          start = 1'b0;
  logic                          busy;
  logic                          op = OP_LOAD;
  logic [LOAD_IDX_W-1:0]         load_index = '0;
  logic signed [LOAD_DAT_W-1:0]  load_height = '0;
  logic signed [COORD_W-1:0]     query_x = '0;
  logic signed [COORD_W-1:0]     query_z = '0;
  logic                          done;
  logic signed [RESULT_W-1:0]    height_out;
  logic                          in_bounds;
  logic                          cfg_valid = 1'b0;
  logic                          cfg_ready;
  logic [CFG_IDX_W-1:0]          cfg_index = '0;
  logic [CFG_DATA_W-1:0]         cfg_data = '0;

  heightmap_bilinear_query DUT (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .op         (op),
    .load_index (load_index),
    .load_height(load_height),
    .query_x    (query_x),
    .query_z    (query_z),
    .done       (done),
    .height_out (height_out),
    .in_bounds  (in_bounds),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // Register copies, written only while the block is idle
  logic [DIM_W-1:0]          map_w  = RST_MAP_WIDTH;
  logic [DIM_W-1:0]          map_h  = RST_MAP_HEIGHT;
  logic [RECIP_W-1:0]        inv_w  = RST_INV_WORLD;
  logic [RECIP_W-1:0]        inv_d  = RST_INV_WORLD;
  logic signed [SCALE_W-1:0] hscale = RST_HEIGHT_SCALE;

  logic [LOAD_DAT_W-1:0] sample_mem [DEF_MAP_ENTRIES];
  bit                    sample_loaded [DEF_MAP_ENTRIES];

  terrain_cmd_t   pending_cmds [$];
  height_result_t expected_heights [$];
  terrain_cmd_t   cur;
  int             idle_left = 0;
  int             idle_odds = 0;

  int unsigned cycle_count = 0;
  int unsigned error_count = 0;
  int unsigned cmds_queued = 0;
  int unsigned cmds_taken = 0;
  int unsigned loads_taken = 0;
  int unsigned queries_taken = 0;
  int unsigned inside_count = 0;
  int unsigned results_checked = 0;
  int unsigned settings_done = 0;

  initial begin
    forever #6 clk = ~clk;
  end

  task automatic report_mismatch(input string what);
    error_count++;
    if (error_count <= PRINT_CAP) begin
      $display("ERROR cycle %0d: %s", cycle_count, what);
    end
  endtask

  // Map a Q15.8 coordinate to Q1.24 unit space; low when outside [0,1].
  function automatic logic to_unit(input logic signed [COORD_W-1:0] c,
                                   input logic [RECIP_W-1:0] inv, output longint u);
    longint cs, iv, s;
    cs = c;
    iv = inv;
    s = cs * iv + (64'sd1 <<< 31);
    u = s >>> 8;
    return (s >= 0) && (u <= (64'sd1 <<< 24));
  endfunction

  function automatic taps_t locate(input logic signed [COORD_W-1:0] qx,
                                   input logic signed [COORD_W-1:0] qz);
    taps_t  t;
    longint ux, uz, w, h, fx, fz, x0, z0, x1, z1;
    logic   okx, okz;
    t = '0;
    okx = to_unit(qx, inv_w, ux);
    okz = to_unit(qz, inv_d, uz);
    t.inb = okx && okz;
    if (!t.inb) return t;
    w = (map_w == 0) ? 64'sd1 : longint'(map_w);
    h = (map_h == 0) ? 64'sd1 : longint'(map_h);
    fx = ux * (w - 1);
    fz = uz * (h - 1);
    x0 = fx >>> 24;
    z0 = fz >>> 24;
    x1 = (x0 + 1 < w) ? x0 + 1 : x0;
    z1 = (z0 + 1 < h) ? z0 + 1 : z0;
    t.ax = FRAC_W'(fx >>> 8);
    t.az = FRAC_W'(fz >>> 8);
    // wrap the address when the map outgrows the store
    t.idx[0] = LOAD_IDX_W'(z0 * w + x0);
    t.idx[1] = LOAD_IDX_W'(z0 * w + x1);
    t.idx[2] = LOAD_IDX_W'(z1 * w + x0);
    t.idx[3] = LOAD_IDX_W'(z1 * w + x1);
    return t;
  endfunction

  function automatic height_result_t scaled_height(input taps_t t);
    height_result_t r;
    longint         b [4];
    longint         ax, az, top, bot, acc, h16, prod, res;
    r = '0;
    if (!t.inb) return r;
    // offset binary keeps every product unsigned
    for (int k = 0; k < 4; k++) begin
      b[k] = longint'(sample_mem[t.idx[k]] ^ 16'h8000);
    end
    ax = longint'(t.ax);
    az = longint'(t.az);
    top = b[0] * (65536 - ax) + b[1] * ax;
    bot = b[2] * (65536 - ax) + b[3] * ax;
    acc = top * (65536 - az) + bot * az;
    h16 = (acc >>> 16) - (64'sd1 <<< 31);
    prod = h16 * longint'(hscale);
    res = prod >>> 24;
    if (res > 64'sd2147483647) res = 64'sd2147483647;
    if (res < -64'sd2147483648) res = -64'sd2147483648;
    r.height = RESULT_W'(res);
    r.in_bounds = 1'b1;
    return r;
  endfunction

  // Driver: present queued commands, with random idle bursts
  always @(posedge clk) begin
    height_result_t want;
    if (rst) begin
      start <= 1'b0;
      idle_left = 0;
    end else begin
      if (start && !busy) begin
        cmds_taken++;
        if (cur.op == OP_LOAD) begin
          sample_mem[cur.load_index] = cur.load_height;
          loads_taken++;
        end else begin
          want = scaled_height(locate(cur.query_x, cur.query_z));
          expected_heights.push_back(want);
          queries_taken++;
          if (want.in_bounds) inside_count++;
        end
      end
      if (!(start && busy)) begin
        if (idle_left > 0) begin
          idle_left--;
          start <= 1'b0;
        end else if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
          idle_left = $urandom_range(0, 7);
          start <= 1'b0;
        end else if (pending_cmds.size() != 0) begin
          cur = pending_cmds.pop_front();
          op <= cur.op;
          load_index <= cur.load_index;
          load_height <= cur.load_height;
          query_x <= cur.query_x;
          query_z <= cur.query_z;
          start <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: every strobe must match the oldest outstanding query
  always @(posedge clk) begin
    height_result_t want;
    if (!rst && done) begin
      if (expected_heights.size() == 0) begin
        report_mismatch("result strobe with no query outstanding");
      end else begin
        want = expected_heights.pop_front();
        results_checked++;
        if (height_out !== want.height) begin
          report_mismatch($sformatf("height_out %0d, expected %0d", height_out, want.height));
        end
        if (in_bounds !== want.in_bounds) begin
          report_mismatch($sformatf("in_bounds %b, expected %b", in_bounds, want.in_bounds));
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Run stopped at cycle limit with %0d results outstanding",
               expected_heights.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_MAP_WIDTH:       map_w = val[DIM_W-1:0];
      REG_MAP_HEIGHT:      map_h = val[DIM_W-1:0];
      REG_INV_WORLD_WIDTH: inv_w = val[RECIP_W-1:0];
      REG_INV_WORLD_DEPTH: inv_d = val[RECIP_W-1:0];
      REG_HEIGHT_SCALE:    hscale = val[SCALE_W-1:0];
      default: ;
    endcase
  endtask

  task automatic configure(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h,
                           input logic [RECIP_W-1:0] iw, input logic [RECIP_W-1:0] id,
                           input logic [SCALE_W-1:0] s);
    logic [CFG_DATA_W-1:0] junk;
    junk = $urandom;
    // junk in the unused upper bits must be dropped
    write_reg(REG_MAP_WIDTH, {junk[CFG_DATA_W-1:DIM_W], w});
    write_reg(REG_MAP_HEIGHT, {~junk[CFG_DATA_W-1:DIM_W], h});
    write_reg(REG_INV_WORLD_WIDTH, iw);
    write_reg(REG_INV_WORLD_DEPTH, id);
    write_reg(REG_HEIGHT_SCALE, {junk[CFG_DATA_W-1:SCALE_W], s});
    settings_done++;
  endtask

  task automatic wait_drained(input int settle);
    while (cmds_taken != cmds_queued || expected_heights.size() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  function automatic logic signed [LOAD_DAT_W-1:0] pick_height();
    case ($urandom_range(0, 15))
      0: return 16'sh7FFF;
      1: return 16'sh8000;
      2: return 16'sh0000;
      3: return 16'shFFFF;
      default: return LOAD_DAT_W'($urandom);
    endcase
  endfunction

  // Bias coordinates towards the terrain and its edges for the given reciprocal.
  function automatic logic signed [COORD_W-1:0] pick_coord(input logic [RECIP_W-1:0] inv);
    longint span, c;
    logic [31:0] r;
    span = (inv == 0) ? COORD_LIM : ((64'sd1 <<< 31) / longint'(inv));
    if (span > COORD_LIM) span = COORD_LIM;
    case ($urandom_range(0, 9))
      0: c = span + longint'($urandom_range(0, 1));
      1: c = -span - longint'($urandom_range(0, 1));
      2, 3: begin
        r = $urandom;
        return r[COORD_W-1:0];
      end
      default: c = longint'($urandom_range(0, 32'(2 * span))) - span;
    endcase
    if (c >= COORD_LIM) c = COORD_LIM - 1;
    if (c < -COORD_LIM) c = -COORD_LIM;
    return COORD_W'(c);
  endfunction

  task automatic queue_load(input logic [LOAD_IDX_W-1:0] idx,
                            input logic signed [LOAD_DAT_W-1:0] value);
    terrain_cmd_t c;
    c.op = OP_LOAD;
    c.load_index = idx;
    c.load_height = value;
    c.query_x = COORD_W'($urandom);
    c.query_z = COORD_W'($urandom);
    sample_loaded[idx] = 1'b1;
    pending_cmds.push_back(c);
    cmds_queued++;
  endtask

  // Fill any neighbour not yet loaded so that no query reads an unwritten sample.
  task automatic queue_query(input logic signed [COORD_W-1:0] qx,
                             input logic signed [COORD_W-1:0] qz);
    terrain_cmd_t c;
    taps_t        t;
    t = locate(qx, qz);
    if (t.inb) begin
      for (int k = 0; k < 4; k++) begin
        if (!sample_loaded[t.idx[k]]) queue_load(t.idx[k], pick_height());
      end
    end
    c.op = OP_QUERY;
    c.load_index = LOAD_IDX_W'($urandom);
    c.load_height = LOAD_DAT_W'($urandom);
    c.query_x = qx;
    c.query_z = qz;
    pending_cmds.push_back(c);
    cmds_queued++;
  endtask

  task automatic run_random(input int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 9) < 3) begin
        queue_load(LOAD_IDX_W'($urandom), pick_height());
      end else begin
        queue_query(pick_coord(inv_w), pick_coord(inv_d));
      end
    end
    wait_drained(SETTLE);
  endtask

  task automatic random_setting();
    logic [RECIP_W-1:0] iw, id;
    iw = ($urandom_range(0, 7) == 0) ? RECIP_W'($urandom) :
         RECIP_W'($urandom_range(32'h0010_0000, 32'h0400_0000));
    id = $urandom_range(32'h0010_0000, 32'h0400_0000);
    configure(DIM_W'($urandom_range(1, 256)), DIM_W'($urandom_range(1, 256)), iw, id,
              SCALE_W'($urandom));
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Defaults: 256 x 256 map over one world unit, so the terrain spans +/-128
    idle_odds = 6;
    queue_load(16'd0, 16'sh7FFF);
    queue_load(16'd255, 16'sh8000);
    queue_load(16'd65280, 16'sh8000);
    queue_load(16'd65535, 16'sh7FFF);
    queue_query(-24'sd128, -24'sd128);
    queue_query(24'sd128, -24'sd128);
    queue_query(-24'sd128, 24'sd128);
    queue_query(24'sd128, 24'sd128);
    queue_query(24'sd127, 24'sd127);
    queue_query(24'sd0, 24'sd0);
    queue_query(24'sd129, 24'sd0);
    queue_query(24'sd0, -24'sd129);
    queue_query(-24'sd8388608, 24'sd8388607);
    queue_query(24'sd8388607, -24'sd8388608);
    run_random(50);

    // Tiny map, and writes to indexes with no register behind them
    idle_odds = 0;
    configure(9'd4, 9'd3, 32'h0040_0000, 32'h0200_0000, 16'shFF80);
    for (int i = int'(REG_HEIGHT_SCALE) + 1; i < (1 << CFG_IDX_W); i++) begin
      write_reg(CFG_IDX_W'(i), $urandom);
    end
    queue_query(-24'sd512, -24'sd64);
    queue_query(24'sd512, 24'sd64);
    run_random(50);

    // Zero dimensions, zero reciprocals, most negative scale
    idle_odds = 4;
    configure(9'd0, 9'd0, 32'h0, 32'h0, 16'sh8000);
    queue_query(24'sd8388607, -24'sd8388608);
    run_random(30);

    // Oversized map wraps the store; largest reciprocal, largest scale
    idle_odds = 8;
    configure(9'd511, 9'd511, 32'hFFFF_FFFF, 32'h0080_0000, 16'sh7FFF);
    queue_query(24'sd0, 24'sd256);
    queue_query(24'sd0, -24'sd256);
    run_random(40);

    // One column, smallest reciprocals: every position lands near the middle
    idle_odds = 3;
    configure(9'd1, 9'd256, 32'h1, 32'h1, 16'shFFFF);
    run_random(40);

    idle_odds = 5;
    configure(9'd256, 9'd1, 32'h0100_0000, 32'h0008_0000, 16'sh0000);
    run_random(30);

    idle_odds = 6;
    random_setting();
    run_random(40);
    idle_odds = 2;
    random_setting();
    run_random(40);

    // Closing stretch at full rate
    idle_odds = 0;
    random_setting();
    run_random(40);

    wait_drained(2 * SETTLE);
    if (expected_heights.size() != 0) begin
      report_mismatch($sformatf("%0d results never arrived", expected_heights.size()));
    end
    $display("Covered %0d loads and %0d queries (%0d inside the terrain) over %0d settings",
             loads_taken, queries_taken, inside_count, settings_done);
    $display("Checked %0d results, %0d errors", results_checked, error_count);
    if (error_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
